### rtl/aes_cbc_pkg.sv
// shared types, constants and byte functions for the aes cbc block
package aes_cbc_pkg;

	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned REG_KEY_W0 = 0;
	localparam int unsigned REG_KEY_W3 = 3;
	localparam int unsigned REG_KEY_SIZE = 4;
	localparam int unsigned REG_DIRECTION = 5;
	localparam int unsigned REG_CHAIN_MODE = 6;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned RK_DEPTH = 60;
	localparam int unsigned RK_AW = 6;

	typedef logic [127:0] blk_t;
	typedef logic [31:0] word_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xt(x);
		end
		gmul = p;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] b;
		logic [7:0] e;
		r = 8'h01;
		b = x;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i]) r = gmul(r, b);
			b = gmul(b, b);
		end
		ginv = r;
	endfunction

	function automatic logic [7:0] rl(input logic [7:0] b, input int n);
		rl = (b << n) | (b >> (8 - n));
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] x);
		logic [7:0] b;
		b = ginv(x);
		sbox_calc = b ^ rl(b, 1) ^ rl(b, 2) ^ rl(b, 3) ^ rl(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] isbox_calc(input logic [7:0] x);
		isbox_calc = ginv(rl(x, 1) ^ rl(x, 3) ^ rl(x, 6) ^ 8'h05);
	endfunction

	typedef logic [7:0] tbl_t [256];

	function automatic tbl_t mk_sbox(input logic inv);
		tbl_t t;
		for (int i = 0; i < 256; i++)
			t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
		mk_sbox = t;
	endfunction

	localparam tbl_t SBOX = mk_sbox(1'b0);
	localparam tbl_t ISBOX = mk_sbox(1'b1);

	function automatic word_t sub_word(input word_t w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic word_t mix_col(input word_t w);
		logic [7:0] a0, a1, a2, a3;
		{a0, a1, a2, a3} = w;
		mix_col = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
			xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
	endfunction

	function automatic word_t inv_mix_col(input word_t w);
		logic [7:0] a0, a1, a2, a3;
		{a0, a1, a2, a3} = w;
		inv_mix_col = {
			gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9),
			gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13),
			gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11),
			gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14)};
	endfunction

endpackage

### rtl/aes_cbc_round.sv
// one shared aes round, forward or inverse, with final-round and key xor
module aes_cbc_round (
	input  aes_cbc_pkg::blk_t s,
	input  aes_cbc_pkg::blk_t rk,
	input  logic              inv,
	input  logic              last,
	output aes_cbc_pkg::blk_t y
);
	logic [7:0] b [16];
	logic [7:0] t [16];
	aes_cbc_pkg::blk_t m;

	always_comb begin
		for (int i = 0; i < 16; i++) b[i] = s[127 - 8 * i -: 8];
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++)
				t[j + 4 * c] = inv ? aes_cbc_pkg::ISBOX[b[j + 4 * ((c + 4 - j) % 4)]]
					: aes_cbc_pkg::SBOX[b[j + 4 * ((c + j) % 4)]];
		for (int c = 0; c < 4; c++) begin
			if (last) m[127 - 32 * c -: 32] = {t[4 * c], t[4 * c + 1], t[4 * c + 2], t[4 * c + 3]};
			else if (inv) m[127 - 32 * c -: 32] = aes_cbc_pkg::inv_mix_col(
				{t[4 * c], t[4 * c + 1], t[4 * c + 2], t[4 * c + 3]});
			else m[127 - 32 * c -: 32] = aes_cbc_pkg::mix_col(
				{t[4 * c], t[4 * c + 1], t[4 * c + 2], t[4 * c + 3]});
		end
		y = m ^ rk;
	end
endmodule

### rtl/aes_block_cipher_cbc.sv
// top level of the aes ecb/cbc block cipher
// usage:
//  config: write key_w0..key_w3, key_size, direction, chain_mode through
//  cfg_we / cfg_index / cfg_data while idle. any write marks the key
//  schedule stale; the next input beat first expands it, one word per
//  cycle (44 or 60 words), writing forward and inverse keys together.
//  in channel: in_valid / in_ready carry data_hi, data_lo, first_block.
//  out channel: out_valid / out_ready carry result_hi, result_lo.
//  the result follows the input beat after nr + 1 rounds, nr being 10
//  for 128-bit keys and 14 for 256-bit keys, plus the schedule expansion
//  after a configuration change.
//  each round fetches four key words through the registered key memory
//  port, then passes through the shared round unit (round 0 adds the key only).
//  one block at a time; in_ready drops while a block is in work and while
//  an earlier result still waits in the output register, so a new beat is
//  taken only once the previous result has left.
//  reset clears the chain value, the registers (chain_mode resets to cbc) and the schedule-valid flag.
//  a stalled receiver holds the result, and the next beat waits for it.
module aes_block_cipher_cbc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [aes_cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aes_cbc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_hi,
	input  logic [63:0] data_lo,
	input  logic        first_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXP  = 3'd1;
	localparam logic [2:0] ST_LD   = 3'd3;
	localparam logic [2:0] ST_RND  = 3'd4;

	logic [63:0] key_q [aes_cbc_pkg::KEY_WORDS];
	logic key_size_q, dir_q, chain_q, sched_ok_q;
	logic [2:0] st_q;
	logic [5:0] widx_q;
	logic [3:0] rnd_q;
	logic [1:0] col_q;
	logic [7:0] rcon_q;
	logic [31:0] w_q [8];
	aes_cbc_pkg::word_t rk_mem [aes_cbc_pkg::RK_DEPTH];
	aes_cbc_pkg::word_t irk_mem [aes_cbc_pkg::RK_DEPTH];
	aes_cbc_pkg::word_t rd_q;
	aes_cbc_pkg::blk_t rkb_q, st_blk_q, cv_q, ct_q, rk_blk;
	aes_cbc_pkg::blk_t rnd_y;
	logic fb_q, ovalid_q;
	logic [127:0] out_q;
	logic [3:0] nr;
	logic [5:0] total;
	aes_cbc_pkg::word_t tword, nword;
	logic [2:0] nk_m;
	aes_cbc_pkg::word_t key_wd, mem_wd, imem_wd;
	logic mem_we;
	logic [aes_cbc_pkg::RK_AW-1:0] mem_wa, mem_ra;
	logic [5:0] rsel;

	assign nr = key_size_q ? 4'd14 : 4'd10;
	assign total = key_size_q ? 6'd60 : 6'd44;
	assign nk_m = key_size_q ? 3'd7 : 3'd3;
	assign in_ready = (st_q == ST_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign result_hi = out_q[127:64];
	assign result_lo = out_q[63:0];

	// key expansion word from the last eight words held in w_q
	always_comb begin
		logic [31:0] t;
		logic [31:0] back;
		t = w_q[0];
		back = key_size_q ? w_q[7] : w_q[3];
		if ((widx_q & {3'd0, nk_m}) == 6'd0)
			tword = aes_cbc_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'd0};
		else if (key_size_q && widx_q[2:0] == 3'd4)
			tword = aes_cbc_pkg::sub_word(t);
		else
			tword = t;
		nword = back ^ tword;
	end

	// schedule words and key memory addresses
	always_comb begin
		key_wd = widx_q[0] ? key_q[widx_q[2:1]][31:0] : key_q[widx_q[2:1]][63:32];
		mem_wd = (widx_q <= {3'd0, nk_m}) ? key_wd : nword;
		imem_wd = (widx_q >= 6'd4 && widx_q < total - 6'd4) ?
			aes_cbc_pkg::inv_mix_col(mem_wd) : mem_wd;
		mem_we = (st_q == ST_EXP);
		mem_wa = widx_q;
		rsel = dir_q ? 6'(nr - rnd_q) : {2'd0, rnd_q};
		mem_ra = {rsel[3:0], col_q};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rk_mem[mem_wa] <= mem_wd;
			irk_mem[mem_wa] <= imem_wd;
		end
		rd_q <= dir_q ? irk_mem[mem_ra] : rk_mem[mem_ra];
	end

	aes_cbc_round u_round (
		.s(st_blk_q), .rk(rk_blk), .inv(dir_q), .last(rnd_q == nr), .y(rnd_y)
	);
	assign rk_blk = rkb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			for (int i = 0; i < 8; i++) w_q[i] <= '0;
			key_size_q <= 1'b0;
			dir_q <= 1'b0;
			chain_q <= 1'b1;
			sched_ok_q <= 1'b0;
			st_q <= ST_IDLE;
			ovalid_q <= 1'b0;
			cv_q <= '0;
			ct_q <= '0;
			fb_q <= 1'b0;
			out_q <= '0;
			st_blk_q <= '0;
			rkb_q <= '0;
			widx_q <= '0;
			rnd_q <= '0;
			col_q <= '0;
			rcon_q <= 8'h01;
		end else begin
			if (cfg_we) begin
				sched_ok_q <= 1'b0;
				if (cfg_index <= 3'(aes_cbc_pkg::REG_KEY_W3))
					key_q[cfg_index[1:0]] <= cfg_data;
				else if (cfg_index == 3'(aes_cbc_pkg::REG_KEY_SIZE)) key_size_q <= cfg_data[0];
				else if (cfg_index == 3'(aes_cbc_pkg::REG_DIRECTION)) dir_q <= cfg_data[0];
				else if (cfg_index == 3'(aes_cbc_pkg::REG_CHAIN_MODE)) chain_q <= cfg_data[0];
			end
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						ct_q <= {data_hi, data_lo};
						fb_q <= first_block;
						widx_q <= '0;
						rcon_q <= 8'h01;
						st_q <= sched_ok_q ? ST_LD : ST_EXP;
					end
				end
				ST_EXP: begin
					if (widx_q > {3'd0, nk_m} && (widx_q & {3'd0, nk_m}) == 6'd0)
						rcon_q <= aes_cbc_pkg::xt(rcon_q);
					for (int i = 7; i > 0; i--) w_q[i] <= w_q[i - 1];
					w_q[0] <= mem_wd;
					if (widx_q == total - 6'd1) begin
						widx_q <= '0;
						sched_ok_q <= 1'b1;
						st_q <= ST_LD;
					end else widx_q <= widx_q + 6'd1;
				end
				ST_LD: begin
					// gather round key words one per cycle, then start the round
					if (widx_q != 6'd0)
						rkb_q <= {rkb_q[95:0], rd_q};
					if (widx_q == 6'd4) begin
						widx_q <= '0;
						col_q <= '0;
						st_q <= ST_RND;
					end else begin
						widx_q <= widx_q + 6'd1;
						col_q <= col_q + 2'd1;
					end
				end
				ST_RND: begin
					aes_cbc_pkg::blk_t cv, x;
					cv = (chain_q && fb_q) ? '0 : cv_q;
					if (rnd_q == 4'd0) begin
						x = (!dir_q && chain_q) ? (ct_q ^ cv) : ct_q;
						st_blk_q <= x ^ rkb_q;
						cv_q <= cv;
						fb_q <= 1'b0;
						rnd_q <= 4'd1;
						st_q <= ST_LD;
					end else if (rnd_q == nr) begin
						x = rnd_y;
						if (dir_q) begin
							if (chain_q) begin
								x = x ^ cv_q;
								cv_q <= ct_q;
							end
						end else if (chain_q) cv_q <= x;
						out_q <= x;
						ovalid_q <= 1'b1;
						rnd_q <= '0;
						st_q <= ST_IDLE;
					end else begin
						st_blk_q <= rnd_y;
						rnd_q <= rnd_q + 4'd1;
						st_q <= ST_LD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result_hi)))
		else $error("result lost under stall");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= nr) else $error("round count overrun");
endmodule
